>>> src/mmi_pkg.sv
// Shared types and constants of the marker match and inject block.
package mmi_pkg;

    localparam int BYTE_W       = 8;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_IDX_W    = 3;
    localparam int MLEN_W       = 4;
    localparam int ILEN_W       = 6;
    localparam int INSERT_WORDS = 4;
    localparam int INS_IDX_W    = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MARKER_BYTES  = 3'd0,
        REG_MARKER_LENGTH = 3'd1,
        REG_INSERT_WORD_0 = 3'd2,
        REG_INSERT_WORD_1 = 3'd3,
        REG_INSERT_WORD_2 = 3'd4,
        REG_INSERT_WORD_3 = 3'd5,
        REG_INSERT_LENGTH = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [MLEN_W-1:0] count;
        logic              hit;
    } match_t;

endpackage

>>> src/marker_match_inject_once_top.sv
// Top level of the marker match and one-time insert stream block.

// Bytes pass from the input stream to a single output register, one byte per
// cycle. Each byte is compared against the configured marker (1 to MARKER_MAX
// bytes); when the first complete match ends, that byte is sent and then the
// configured insert bytes follow, one per cycle from the same output register,
// with tuser set. During that burst the input is held off until every insert
// byte (insert_length, capped at INSERT_MAX) has been loaded, and longer
// while the output stalls; after it the block is a plain pass-through for good.
// Outside the burst the input is ready whenever the output register is empty or
// being drained, so throughput is one byte per cycle unless the output stalls.
// Write configuration only while the stream is idle.
module marker_match_inject_once_top #(
    parameter int MARKER_MAX = 8,
    parameter int INSERT_MAX = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // [7:0] in_byte
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [7:0]                          m_axis_tdata,  // [7:0] out_byte
    output logic [0:0]                          m_axis_tuser,  // [0] is_inserted
    output logic                                m_axis_tlast,
    input  logic                                cfg_we,
    input  logic [mmi_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mmi_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int INS_BITS = mmi_pkg::INSERT_WORDS * mmi_pkg::CFG_DATA_W;

    logic [mmi_pkg::CFG_DATA_W-1:0] marker_bytes_reg;
    logic [mmi_pkg::MLEN_W-1:0]     marker_length_reg;
    logic [mmi_pkg::CFG_DATA_W-1:0] insert_word_reg [mmi_pkg::INSERT_WORDS];
    logic [mmi_pkg::ILEN_W-1:0]     insert_length_reg;

    logic [mmi_pkg::MLEN_W-1:0]     match_count_reg, match_count_next;
    logic                           done_reg, done_next;
    logic                           ins_active_reg, ins_active_next;
    logic [mmi_pkg::INS_IDX_W-1:0]  ins_idx_reg, ins_idx_next;
    logic [mmi_pkg::ILEN_W-1:0]     ins_len_reg, ins_len_next;

    logic                           out_valid_reg, out_valid_next;
    logic [mmi_pkg::BYTE_W-1:0]     out_byte_reg, out_byte_next;
    logic                           out_ins_reg, out_ins_next;
    logic                           out_last_reg, out_last_next;

    logic                           out_free;
    logic                           in_accept;
    logic [mmi_pkg::ILEN_W-1:0]     ilen;
    logic [INS_BITS-1:0]            insert_vec;
    logic                           ins_last;
    mmi_pkg::match_t                match;

    mmi_match #(
        .MARKER_MAX (MARKER_MAX)
    ) u_match (
        .in_byte       (s_axis_tdata),
        .match_count   (match_count_reg),
        .marker_bytes  (marker_bytes_reg),
        .marker_length (marker_length_reg),
        .result        (match)
    );

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = out_free && !ins_active_reg;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_byte_reg;
    assign m_axis_tuser[0] = out_ins_reg;
    assign m_axis_tlast    = out_last_reg;

    assign insert_vec = {insert_word_reg[3], insert_word_reg[2],
                         insert_word_reg[1], insert_word_reg[0]};
    assign ilen       = (insert_length_reg > mmi_pkg::ILEN_W'(INSERT_MAX))
                        ? mmi_pkg::ILEN_W'(INSERT_MAX) : insert_length_reg;
    assign ins_last   = ({1'b0, ins_idx_reg} + mmi_pkg::ILEN_W'(1)) == ins_len_reg;

    always_comb
    begin
        match_count_next = match_count_reg;
        done_next        = done_reg;
        ins_active_next  = ins_active_reg;
        ins_idx_next     = ins_idx_reg;
        ins_len_next     = ins_len_reg;
        out_valid_next   = out_valid_reg;
        out_byte_next    = out_byte_reg;
        out_ins_next     = out_ins_reg;
        out_last_next    = out_last_reg;

        if (out_free)
        begin
            out_valid_next = 1'b0;
            if (ins_active_reg)
            begin
                out_valid_next  = 1'b1;
                out_byte_next   = insert_vec[ins_idx_reg*mmi_pkg::BYTE_W +: mmi_pkg::BYTE_W];
                out_ins_next    = 1'b1;
                out_last_next   = ins_last;
                ins_idx_next    = ins_idx_reg + mmi_pkg::INS_IDX_W'(1);
                ins_active_next = !ins_last;
            end
            else if (in_accept)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = s_axis_tdata;
                out_ins_next   = 1'b0;
                out_last_next  = 1'b1;
                if (!done_reg)
                begin
                    match_count_next = match.count;
                    if (match.hit)
                    begin
                        done_next       = 1'b1;
                        out_last_next   = (ilen == '0);
                        ins_active_next = (ilen != '0);
                        ins_idx_next    = '0;
                        ins_len_next    = ilen;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_count_reg <= '0;
            done_reg        <= 1'b0;
            ins_active_reg  <= 1'b0;
            ins_idx_reg     <= '0;
            ins_len_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            match_count_reg <= match_count_next;
            done_reg        <= done_next;
            ins_active_reg  <= ins_active_next;
            ins_idx_reg     <= ins_idx_next;
            ins_len_reg     <= ins_len_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_ins_reg  <= out_ins_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_bytes_reg   <= '0;
            marker_length_reg  <= mmi_pkg::MLEN_W'(1);
            insert_word_reg[0] <= '0;
            insert_word_reg[1] <= '0;
            insert_word_reg[2] <= '0;
            insert_word_reg[3] <= '0;
            insert_length_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (mmi_pkg::cfg_idx_t'(cfg_index))
                mmi_pkg::REG_MARKER_BYTES:  marker_bytes_reg   <= cfg_data;
                mmi_pkg::REG_MARKER_LENGTH:
                    marker_length_reg <= cfg_data[mmi_pkg::MLEN_W-1:0];
                mmi_pkg::REG_INSERT_WORD_0: insert_word_reg[0] <= cfg_data;
                mmi_pkg::REG_INSERT_WORD_1: insert_word_reg[1] <= cfg_data;
                mmi_pkg::REG_INSERT_WORD_2: insert_word_reg[2] <= cfg_data;
                mmi_pkg::REG_INSERT_WORD_3: insert_word_reg[3] <= cfg_data;
                mmi_pkg::REG_INSERT_LENGTH:
                    insert_length_reg <= cfg_data[mmi_pkg::ILEN_W-1:0];
                default: ;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_burst_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        ins_active_reg |-> !s_axis_tready)
        else $error("input ready during insert burst");

    a_burst_after_match: assert property (@(posedge clk) disable iff (!rst_n)
        ins_active_reg |-> done_reg)
        else $error("insert burst without completed match");

    a_match_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !done_reg && match.hit) |=> (done_reg && match_count_reg == '0))
        else $error("complete match did not end the search");

    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> (done_reg && match_count_reg == '0))
        else $error("search resumed after insertion");
`endif

endmodule

>>> src/mmi_match.sv
// Marker comparison: next match count and complete-match flag for one byte.
module mmi_match #(
    parameter int MARKER_MAX = 8
) (
    input  logic [mmi_pkg::BYTE_W-1:0]     in_byte,
    input  logic [mmi_pkg::MLEN_W-1:0]     match_count,
    input  logic [mmi_pkg::CFG_DATA_W-1:0] marker_bytes,
    input  logic [mmi_pkg::MLEN_W-1:0]     marker_length,
    output mmi_pkg::match_t                result
);

    logic [mmi_pkg::MLEN_W-1:0] mlen;
    logic [mmi_pkg::MLEN_W-1:0] cnt;
    logic [mmi_pkg::MLEN_W-1:0] cnt_new;
    logic [mmi_pkg::BYTE_W-1:0] marker_cur;
    logic [mmi_pkg::BYTE_W-1:0] marker_first;

    always_comb
    begin
        if (marker_length == '0)
            mlen = mmi_pkg::MLEN_W'(1);
        else if (marker_length > mmi_pkg::MLEN_W'(MARKER_MAX))
            mlen = mmi_pkg::MLEN_W'(MARKER_MAX);
        else
            mlen = marker_length;

        cnt = (match_count >= mlen) ? '0 : match_count;

        marker_cur   = marker_bytes[cnt[2:0]*mmi_pkg::BYTE_W +: mmi_pkg::BYTE_W];
        marker_first = marker_bytes[mmi_pkg::BYTE_W-1:0];

        if (marker_cur == in_byte)
            cnt_new = cnt + mmi_pkg::MLEN_W'(1);
        else if (marker_first == in_byte)
            cnt_new = mmi_pkg::MLEN_W'(1);
        else
            cnt_new = '0;

        result.hit   = (cnt_new >= mlen);
        result.count = result.hit ? '0 : cnt_new;
    end

endmodule
